/* hw/rtl/qrr_pkg.sv */
// qrr_pkg: shared types and constants for the quadratic real roots block.
// No dependencies.
`default_nettype none
package qrr_pkg;
    typedef enum logic [1:0] {
        KIND_TWO     = 2'd0,
        KIND_ONE     = 2'd1,
        KIND_COMPLEX = 2'd2,
        KIND_A_ZERO  = 2'd3
    } t_kind;

    typedef struct packed {
        logic signed [15:0] coef_a;
        logic signed [15:0] coef_b;
        logic signed [15:0] coef_c;
    } t_in;

    typedef struct packed {
        logic signed [31:0] root_plus;
        logic signed [31:0] root_minus;
        t_kind              root_kind;
    } t_out;

    localparam int DISC_W = 35;
    localparam int SQRT_W = 18;
    localparam int NUM_W  = 19;
    localparam int QUO_W  = 36;
    localparam int DEN_W  = 17;
endpackage
`default_nettype wire

/* hw/rtl/quadratic_real_roots_top.sv */
// quadratic_real_roots_top: real roots of a*x^2+b*x+c, Q8.8 in, Q16.16 out.
// Depends on qrr_pkg and qrr_div.
//
// Usage: drive i_in and pulse i_start; o_busy is always low, so an item is
// taken every cycle. Each item gives one result on o_out with o_done high for
// exactly one cycle, in order. The path has 2 + 18 + 1 + 35 + 1 = 57 register
// stages: a product stage, a discriminant stage, an 18-stage square root
// (one result bit per stage), a sign/magnitude stage, a 35-stage divider
// (one quotient bit per stage) and an output register. The first stage loads
// on the accepting edge. Throughput is one item per cycle. The receiver cannot
// stall; results must be taken when shown. Synchronous reset clears the valid
// bits, discarding items in flight; payload registers are not reset.
`default_nettype none
module quadratic_real_roots_top
    import qrr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_in  i_in,
    output logic      o_busy,
    output logic      o_done,
    output t_out      o_out
);
    localparam int SQ_N = SQRT_W;
    localparam int DV_N = NUM_W + 16;
    localparam int LAT  = 2 + SQ_N + 1 + DV_N;

    typedef struct packed {
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic               az;
    } t_side;

    assign o_busy = 1'b0;

    // stage 1: products
    logic signed [31:0] r_bb, r_ac;
    t_side r_s1;
    always_ff @(posedge i_clk) begin
        r_bb <= i_in.coef_b * i_in.coef_b;
        r_ac <= i_in.coef_a * i_in.coef_c;
        r_s1 <= '{a: i_in.coef_a, b: i_in.coef_b, az: (i_in.coef_a == 16'sd0)};
    end

    // stage 2: discriminant
    logic signed [DISC_W-1:0] r_disc;
    t_side r_s2;
    always_ff @(posedge i_clk) begin
        r_disc <= DISC_W'(r_bb) - (DISC_W'(r_ac) <<< 2);
        r_s2   <= r_s1;
    end

    // square root, one bit per stage on non-restoring-free restoring scheme
    logic [2*SQ_N-1:0] r_sv [0:SQ_N];
    logic [SQ_N-1:0]   r_sq [0:SQ_N];
    logic [SQ_N+1:0]   r_sr [0:SQ_N];
    t_side             r_ss [0:SQ_N];
    logic [1:0]        r_sk [0:SQ_N];
    always_comb begin
        r_sv[0] = r_disc[DISC_W-1] ? '0 : (2*SQ_N)'(r_disc);
        r_sq[0] = '0;
        r_sr[0] = '0;
        r_ss[0] = r_s2;
        priority if (r_s2.az)       r_sk[0] = KIND_A_ZERO;
        else if (r_disc[DISC_W-1])  r_sk[0] = KIND_COMPLEX;
        else if (r_disc == '0)      r_sk[0] = KIND_ONE;
        else                        r_sk[0] = KIND_TWO;
    end
    for (genvar g = 0; g < SQ_N; g++) begin : g_sq
        logic [SQ_N+1:0] n_r, n_t;
        always_comb begin
            n_r = {r_sr[g][SQ_N-1:0], r_sv[g][2*SQ_N-1 -: 2]};
            n_t = n_r - {r_sq[g], 2'b01};
        end
        always_ff @(posedge i_clk) begin
            r_sv[g+1] <= {r_sv[g][2*SQ_N-3:0], 2'b00};
            r_ss[g+1] <= r_ss[g];
            r_sk[g+1] <= r_sk[g];
            if (!n_t[SQ_N+1]) begin
                r_sr[g+1] <= n_t;
                r_sq[g+1] <= {r_sq[g][SQ_N-2:0], 1'b1};
            end else begin
                r_sr[g+1] <= n_r;
                r_sq[g+1] <= {r_sq[g][SQ_N-2:0], 1'b0};
            end
        end
    end

    // sign/magnitude setup
    logic signed [NUM_W:0] n_np, n_nm;
    logic [NUM_W-1:0] r_mp, r_mm;
    logic [DEN_W-1:0] r_den;
    logic r_sp, r_sm;
    logic [1:0] r_k3;
    always_comb begin
        n_np = -(NUM_W+1)'(r_ss[SQ_N].b) + (NUM_W+1)'(signed'({1'b0, r_sq[SQ_N]}));
        n_nm = -(NUM_W+1)'(r_ss[SQ_N].b) - (NUM_W+1)'(signed'({1'b0, r_sq[SQ_N]}));
    end
    always_ff @(posedge i_clk) begin
        r_mp  <= n_np[NUM_W] ? NUM_W'(-n_np) : NUM_W'(n_np);
        r_mm  <= n_nm[NUM_W] ? NUM_W'(-n_nm) : NUM_W'(n_nm);
        r_den <= r_ss[SQ_N].a[15] ? DEN_W'(-(17'(r_ss[SQ_N].a)) <<< 1)
                                  : DEN_W'((17'(r_ss[SQ_N].a)) <<< 1);
        r_sp  <= n_np[NUM_W] ^ r_ss[SQ_N].a[15];
        r_sm  <= n_nm[NUM_W] ^ r_ss[SQ_N].a[15];
        r_k3  <= r_sk[SQ_N];
    end

    logic [QUO_W-1:0] w_qp, w_qm;
    qrr_div u_divp (.i_clk(i_clk), .i_num(r_mp), .i_den(r_den), .o_quo(w_qp));
    qrr_div u_divm (.i_clk(i_clk), .i_num(r_mm), .i_den(r_den), .o_quo(w_qm));

    logic       r_dsp [0:DV_N];
    logic       r_dsm [0:DV_N];
    logic [1:0] r_dk  [0:DV_N];
    always_comb begin
        r_dsp[0] = r_sp;
        r_dsm[0] = r_sm;
        r_dk[0]  = r_k3;
    end
    for (genvar g = 0; g < DV_N; g++) begin : g_dd
        always_ff @(posedge i_clk) begin
            r_dsp[g+1] <= r_dsp[g];
            r_dsm[g+1] <= r_dsm[g];
            r_dk[g+1]  <= r_dk[g];
        end
    end

    function automatic logic [31:0] sat(input logic [QUO_W-1:0] m, input logic neg);
        logic [QUO_W:0] v;
        begin
            v = neg ? -({1'b0, m}) : {1'b0, m};
            if (!neg && m > QUO_W'(32'h7FFF_FFFF))      sat = 32'h7FFF_FFFF;
            else if (neg && m > QUO_W'(33'h8000_0000))  sat = 32'h8000_0000;
            else                                        sat = v[31:0];
        end
    endfunction

    logic [LAT-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            o_done <= 1'b0;
        end else begin
            r_vld  <= {r_vld[LAT-2:0], i_start};
            o_done <= r_vld[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        o_out.root_kind <= t_kind'(r_dk[DV_N]);
        if (r_dk[DV_N] == KIND_A_ZERO || r_dk[DV_N] == KIND_COMPLEX) begin
            o_out.root_plus  <= '0;
            o_out.root_minus <= '0;
        end else begin
            o_out.root_plus  <= sat(w_qp, r_dsp[DV_N]);
            o_out.root_minus <= sat(w_qm, r_dsm[DV_N]);
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/qrr_div.sv */
// qrr_div: pipelined restoring divider, one quotient bit per stage.
// Magnitude quotient of (num << 16) / den. Depends on qrr_pkg.
`default_nettype none
module qrr_div
    import qrr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic [NUM_W-1:0]   i_num,
    input  wire logic [DEN_W-1:0]   i_den,
    output logic      [QUO_W-1:0]   o_quo
);
    localparam int N = NUM_W + 16;
    localparam int RW = DEN_W + 1;

    logic [N-1:0]  r_dvd [0:N];
    logic [RW-1:0] r_rem [0:N];
    logic [DEN_W-1:0] r_den [0:N];

    always_comb begin
        r_dvd[0] = {i_num, 16'd0};
        r_rem[0] = '0;
        r_den[0] = i_den;
    end

    for (genvar g = 0; g < N; g++) begin : g_st
        logic [RW-1:0] n_trial;
        logic [RW-1:0] n_sh;
        always_comb begin
            n_sh    = {r_rem[g][RW-2:0], r_dvd[g][N-1]};
            n_trial = n_sh - {1'b0, r_den[g]};
        end
        always_ff @(posedge i_clk) begin
            r_den[g+1] <= r_den[g];
            if (!n_trial[RW-1]) begin
                r_rem[g+1] <= n_trial;
                r_dvd[g+1] <= {r_dvd[g][N-2:0], 1'b1};
            end else begin
                r_rem[g+1] <= n_sh;
                r_dvd[g+1] <= {r_dvd[g][N-2:0], 1'b0};
            end
        end
    end

    assign o_quo = QUO_W'(r_dvd[N]);
endmodule
`default_nettype wire

/* hw/rtl/qrr_check.sv */
// qrr_check: port-level assertions for quadratic_real_roots_top, with bind.
// Depends on qrr_pkg.
`default_nettype none
module qrr_check
    import qrr_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_busy,
    input wire logic o_done,
    input wire t_out o_out
);
    a_busy: assert property (@(posedge i_clk) !o_busy)
        else $error("busy raised");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_done)
        else $error("done after reset");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_out.root_kind == KIND_COMPLEX || o_out.root_kind == KIND_A_ZERO)
        |-> o_out.root_plus == 32'd0 && o_out.root_minus == 32'd0)
        else $error("nonzero roots");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_out.root_kind == KIND_ONE |-> o_out.root_plus == o_out.root_minus)
        else $error("repeated root differs");
endmodule

bind quadratic_real_roots_top qrr_check u_chk (.*);
`default_nettype wire
